// ===== design/ohr_pkg.sv =====
package ohr_pkg;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int POS_W  = 6;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef struct packed {
    logic              func;
    logic [DATA_W-1:0] item_data;
    logic [CNT_W-1:0]  read_count;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] item_out;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  copied_count;
    logic              entry_valid;
    logic              last;
  } out_word_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic              is_read;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  n;
  } cmd_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== design/ohr_front.sv =====
module ohr_front
  import ohr_pkg::*;
(
  input  in_word_t              in_word,
  input  logic [CNT_W-1:0]      cnt,
  output cmd_t                  cmd
);

  // Classify the word and saturate the read count to the entries in use
  always_comb begin
    cmd.is_read = (in_word.func == FUNC_READ);
    cmd.data    = in_word.item_data;
    cmd.n       = (in_word.read_count < cnt) ? in_word.read_count : cnt;
  end

endmodule

// ===== design/ohr_queue.sv =====
module ohr_queue
  import ohr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   head_cmd,
  output qstat_t stat
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push, do_pop;

  assign do_push = push && (fill_r != 2'd2);
  assign do_pop  = pop && (fill_r != 2'd0);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!do_push && do_pop) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Hold queued words
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd   = q_r[rd_ptr_r];
  assign stat.full  = (fill_r == 2'd2);
  assign stat.empty = (fill_r == 2'd0);

endmodule

// ===== design/ohr_back.sv =====
module ohr_back
  import ohr_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  cmd_t             head_cmd,
  input  qstat_t           qstat,
  output logic             pop,
  output logic [CNT_W-1:0] cnt,
  output logic             out_strobe,
  output out_word_t        out_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = (ITEM_WIDTH < DATA_W) ? ITEM_WIDTH : DATA_W;

  typedef enum logic {ST_IDLE, ST_STREAM} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    wi_r, wi_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [POS_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [DEPTH-1:0] vbits_r, vbits_nxt;
  logic             pend_r, pend_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic             ev_r, ev_nxt;
  logic             last_r, last_nxt;
  logic             vld_r, vld_nxt;
  logic [SW-1:0]    mem [DEPTH];
  logic [SW-1:0]    rd_data_r;
  logic             wr_en, rd_en;
  logic [CNT_W-1:0] wi_inc, slot_inc, start_sum, k_inc;
  logic             k_last;

  assign pop   = (state_r == ST_IDLE) && !qstat.empty;
  assign wr_en = pop && !head_cmd.is_read;
  assign rd_en = (state_r == ST_STREAM);

  assign wi_inc    = CNT_W'(wi_r) + CNT_W'(1);
  assign slot_inc  = CNT_W'(slot_r) + CNT_W'(1);
  assign start_sum = CNT_W'(wi_r) + cnt_r - head_cmd.n;
  assign k_inc     = CNT_W'(k_r) + CNT_W'(1);
  assign k_last    = (k_inc == n_r);

  // Sequence inserts, reads and configuration writes
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    wi_nxt    = wi_r;
    slot_nxt  = slot_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    vbits_nxt = vbits_r;
    pend_nxt  = 1'b0;
    pos_nxt   = pos_r;
    ocnt_nxt  = ocnt_r;
    ev_nxt    = ev_r;
    last_nxt  = last_r;
    vld_nxt   = vld_r;

    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          if (!head_cmd.is_read) begin
            vbits_nxt[wi_r] = 1'b1;
            wi_nxt = (wi_inc == cnt_r) ? '0 : AW'(wi_inc);
          end else if (head_cmd.n == '0) begin
            pend_nxt = 1'b1;
            pos_nxt  = '0;
            ocnt_nxt = '0;
            ev_nxt   = 1'b0;
            last_nxt = 1'b1;
          end else begin
            slot_nxt  = (start_sum >= cnt_r) ? AW'(start_sum - cnt_r) : AW'(start_sum);
            k_nxt     = '0;
            n_nxt     = head_cmd.n;
            state_nxt = ST_STREAM;
          end
        end
      end
      ST_STREAM: begin
        pend_nxt = 1'b1;
        pos_nxt  = k_r;
        ocnt_nxt = n_r;
        ev_nxt   = 1'b1;
        last_nxt = k_last;
        vld_nxt  = vbits_r[slot_r];
        slot_nxt = (slot_inc == cnt_r) ? '0 : AW'(slot_inc);
        k_nxt    = POS_W'(k_inc);
        if (k_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Clamp the entry count and restart the write index
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        cnt_nxt = CNT_W'(1);
      end else if (cfg_wdata > CNT_W'(DEPTH)) begin
        cnt_nxt = CNT_W'(DEPTH);
      end else begin
        cnt_nxt = cfg_wdata;
      end
      wi_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= CNT_W'(DEPTH);
      wi_r    <= '0;
      vbits_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wi_r    <= wi_nxt;
      vbits_r <= vbits_nxt;
      pend_r  <= pend_nxt;
    end
    slot_r <= slot_nxt;
    k_r    <= k_nxt;
    n_r    <= n_nxt;
    pos_r  <= pos_nxt;
    ocnt_r <= ocnt_nxt;
    ev_r   <= ev_nxt;
    last_r <= last_nxt;
    vld_r  <= vld_nxt;
  end

  // Ring store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wi_r] <= head_cmd.data[SW-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem[slot_r];
    end
  end

  // Drive the result word; a never-written entry reads as zero
  assign cnt                   = cnt_r;
  assign out_strobe            = pend_r;
  assign out_word.item_out     = (ev_r && vld_r) ? DATA_W'(rd_data_r) : '0;
  assign out_word.position     = pos_r;
  assign out_word.copied_count = ocnt_r;
  assign out_word.entry_valid  = ev_r;
  assign out_word.last         = last_r;

  a_wi_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(wi_r) < cnt_r)
    else $error("write index beyond entry count");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STREAM) |-> (CNT_W'(slot_r) < cnt_r))
    else $error("read slot beyond entry count");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !ev_r) |-> (last_r && (ocnt_r == '0) && (out_word.item_out == '0)))
    else $error("malformed empty read word");

  a_pos_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && ev_r) |-> (CNT_W'(pos_r) < ocnt_r))
    else $error("position not below copied count");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_STREAM) && k_last) |=> (state_r == ST_IDLE) && pend_r && last_r)
    else $error("read run did not end on last word");

endmodule

// ===== design/overwrite_ring_history_unit.sv =====
// Channel  Ports                          Handshake
// in       start, busy, in_word           taken when start && !busy
// out      out_strobe, out_word           one strobe per word, no backpressure
// cfg      cfg_we, cfg_wdata              written when cfg_we
//
// An insert leaves the back end idle, so inserts are taken every cycle unless busy.
// A read of n entries streams one word per cycle from the single read port; its
// first word passes the state register and then the registered read port after the
// read leaves the 2-entry queue, and a read of zero gives its word in the next cycle.
// Reset is synchronous and clears the store's valid bits at once: no clearing pass.
// busy rises while the command queue is full; results are never held back.
module overwrite_ring_history_unit
  import ohr_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  output logic             out_strobe,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  cmd_t             front_cmd;
  cmd_t             head_cmd;
  qstat_t           qstat;
  logic             pop;
  logic [CNT_W-1:0] cnt;

  assign busy = qstat.full;

  // Classify incoming words
  ohr_front u_front (
    .in_word (in_word),
    .cnt     (cnt),
    .cmd     (front_cmd)
  );

  // Decouple acceptance from execution
  ohr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (start && !busy),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (qstat)
  );

  // Execute inserts and stream reads
  ohr_back #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_cmd   (head_cmd),
    .qstat      (qstat),
    .pop        (pop),
    .cnt        (cnt),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
